// ===== hw/rtl/lkvc_pkg.sv =====
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int CAP_BITS   = 5;

    localparam int SLOT_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_BITS  = SLOT_BITS;
    localparam int COUNT_BITS = $clog2(ENTRIES + 1);
    // wide enough for the capacity register and the fill count alike
    localparam int CMP_BITS   = 8;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic                  operation;
        logic [KEY_BITS-1:0]   lookup_key;
        logic [VALUE_BITS-1:0] write_value;
    } in_item_t;

    typedef struct packed {
        logic                  key_found;
        logic [VALUE_BITS-1:0] read_value;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic match;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lkvc_ctrl.sv =====
`default_nettype none

module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        state_reg   <= ST_MATCH;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_MATCH: begin
                    state_reg <= ST_COMMIT;
                end
                ST_COMMIT: begin
                    // hold the update until the output register can take the result
                    if (status.out_free) begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_ready     = s_ready_reg;
    assign cmd.capture = s_valid && s_ready_reg;
    assign cmd.match   = (state_reg == ST_MATCH);
    assign cmd.commit  = (state_reg == ST_COMMIT) && status.out_free;

endmodule

`default_nettype wire

// ===== hw/rtl/lkvc_datapath.sv =====
`default_nettype none

module lkvc_datapath
    import lkvc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire in_item_t            s_item,
    output out_item_t                m_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire logic                cfg_wr_en,
    input  wire logic [CAP_BITS-1:0] cfg_wr_data,
    input  wire dp_cmd_t             cmd,
    output dp_status_t               status
);

    logic [KEY_BITS-1:0]   keys_reg   [ENTRIES];
    logic [VALUE_BITS-1:0] values_reg [ENTRIES];
    logic [RANK_BITS-1:0]  rank_reg   [ENTRIES];
    logic [COUNT_BITS-1:0] fill_reg;
    logic [CAP_BITS-1:0]   cap_reg;

    in_item_t              item_reg;
    logic                  hit_reg;
    logic [SLOT_BITS-1:0]  hit_slot_reg;
    logic [RANK_BITS-1:0]  hit_rank_reg;
    logic [SLOT_BITS-1:0]  victim_slot_reg;
    logic [RANK_BITS-1:0]  victim_rank_reg;
    logic                  full_reg;
    logic [VALUE_BITS-1:0] hit_value_reg;

    out_item_t             out_reg;
    logic                  out_valid_reg;

    logic [ENTRIES-1:0]    valid_vec;
    logic                  hit_next;
    logic [SLOT_BITS-1:0]  hit_slot_next;
    logic [SLOT_BITS-1:0]  victim_slot_next;
    logic [COUNT_BITS-1:0] last_rank;
    logic [CMP_BITS-1:0]   cap_eff;
    logic                  full_next;

    logic                  is_put;
    logic                  do_update;
    logic                  do_write_key;
    logic                  do_insert;
    logic [SLOT_BITS-1:0]  target_slot;
    logic [COUNT_BITS-1:0] threshold;

    // slots fill in index order and are never freed, so slot i is valid iff i < fill count
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            valid_vec[i] = (COUNT_BITS'(i) < fill_reg);
        end
    end

    always_comb begin
        hit_next      = 1'b0;
        hit_slot_next = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (valid_vec[i] && keys_reg[i] == item_reg.lookup_key) begin
                hit_next      = 1'b1;
                hit_slot_next = SLOT_BITS'(i);
            end
        end
    end

    // valid ranks are a permutation of 0..fill-1, so the oldest holds rank fill-1
    assign last_rank = fill_reg - COUNT_BITS'(1);

    always_comb begin
        victim_slot_next = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (valid_vec[i] && COUNT_BITS'(rank_reg[i]) == last_rank) begin
                victim_slot_next = SLOT_BITS'(i);
            end
        end
    end

    always_comb begin
        priority if (cap_reg == '0) begin
            cap_eff = CMP_BITS'(1);
        end else if (CMP_BITS'(cap_reg) > CMP_BITS'(ENTRIES)) begin
            cap_eff = CMP_BITS'(ENTRIES);
        end else begin
            cap_eff = CMP_BITS'(cap_reg);
        end
    end

    assign full_next = (CMP_BITS'(fill_reg) >= cap_eff);

    assign is_put       = (item_reg.operation == OP_PUT);
    assign do_update    = hit_reg || is_put;
    assign do_write_key = !hit_reg && is_put;
    assign do_insert    = do_write_key && !full_reg;

    always_comb begin
        priority if (hit_reg) begin
            target_slot = hit_slot_reg;
            threshold   = COUNT_BITS'(hit_rank_reg);
        end else if (full_reg) begin
            target_slot = victim_slot_reg;
            threshold   = COUNT_BITS'(victim_rank_reg);
        end else begin
            target_slot = SLOT_BITS'(fill_reg);
            threshold   = fill_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_item;
        end
        if (cmd.match) begin
            hit_reg         <= hit_next;
            hit_slot_reg    <= hit_slot_next;
            hit_rank_reg    <= rank_reg[hit_slot_next];
            hit_value_reg   <= values_reg[hit_slot_next];
            victim_slot_reg <= victim_slot_next;
            victim_rank_reg <= rank_reg[victim_slot_next];
            full_reg        <= full_next;
        end
        if (cmd.commit) begin
            if (do_write_key) begin
                keys_reg[target_slot] <= item_reg.lookup_key;
            end
            if (is_put) begin
                values_reg[target_slot] <= item_reg.write_value;
            end
            out_reg.key_found  <= hit_reg;
            out_reg.read_value <= (hit_reg && !is_put) ? hit_value_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
            fill_reg      <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.commit && do_update) begin
                // entries newer than the target age by one; the target becomes newest
                for (int i = 0; i < ENTRIES; i++) begin
                    if (SLOT_BITS'(i) == target_slot) begin
                        rank_reg[i] <= '0;
                    end else if (valid_vec[i] && COUNT_BITS'(rank_reg[i]) < threshold) begin
                        rank_reg[i] <= rank_reg[i] + RANK_BITS'(1);
                    end
                end
            end
            if (cmd.commit && do_insert) begin
                fill_reg <= fill_reg + COUNT_BITS'(1);
            end
            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_item          = out_reg;
    assign m_valid         = out_valid_reg;
    assign status.out_free = !out_valid_reg || m_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/lru_key_value_cache_top.sv =====
`default_nettype none

// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   s_item  (operation, lookup_key, write_value)
// m_       out        m_valid / m_ready   m_item  (key_found, read_value)
// cfg_     in         cfg_wr_en           cfg_wr_data (capacity_in_use)
//
// Each item goes through accept, then parallel key match and victim pick, then commit.
// The commit cycle writes the entry table, the recency ranks and the output register.
// A new item is accepted once the previous one has committed; the result may still be waiting.
// If the output register is full and not being drained, commit waits in place.
// Synchronous active-low reset empties the store and sets the capacity to 16.

module lru_key_value_cache_top
    import lkvc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire in_item_t            s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output out_item_t                m_item,
    input  wire logic                cfg_wr_en,
    input  wire logic [CAP_BITS-1:0] cfg_wr_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    lkvc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lkvc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_item      (s_item),
        .m_item      (m_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

`default_nettype wire
